// ===== hdl/mls_pkg.sv =====
// mls_pkg: types and constants shared by the modem link sequencer
// no dependencies; compiled first

package mls_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int LIMIT_W    = 16;
  localparam int RETRY_W    = 3;
  localparam int HOLD_W     = 13;
  localparam int DEV_W      = 3;
  localparam int LAMP_W     = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_SHORT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_MODE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_JOIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TCP   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_LEAVE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RETRY_LIMIT   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ERROR_HOLD    = 3'd6;

  // reset values of the configuration registers
  localparam logic [LIMIT_W-1:0] RST_TIMEOUT_SHORT = 16'd3000;
  localparam logic [LIMIT_W-1:0] RST_TIMEOUT_MODE  = 16'd6000;
  localparam logic [LIMIT_W-1:0] RST_TIMEOUT_JOIN  = 16'd8000;
  localparam logic [LIMIT_W-1:0] RST_TIMEOUT_TCP   = 16'd9000;
  localparam logic [LIMIT_W-1:0] RST_TIMEOUT_LEAVE = 16'd4000;
  localparam logic [RETRY_W-1:0] RST_RETRY_LIMIT   = 3'd3;
  localparam logic [HOLD_W-1:0]  RST_ERROR_HOLD    = 13'd5000;

  typedef enum logic [1:0] {
    MODE_IDLE       = 2'd0,
    MODE_CONNECT    = 2'd1,
    MODE_DISCONNECT = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    CONN_WAIT_RESET = 3'd0,
    CONN_AT         = 3'd1,
    CONN_MODE       = 3'd2,
    CONN_JOIN       = 3'd3,
    CONN_TCP        = 3'd4,
    CONN_DONE       = 3'd5,
    CONN_ERROR      = 3'd6
  } conn_phase_t;

  typedef enum logic [1:0] {
    DISC_CLOSE   = 2'd0,
    DISC_LEAVE   = 2'd1,
    DISC_RESTORE = 2'd2,
    DISC_ERROR   = 2'd3
  } disc_phase_t;

  typedef enum logic [2:0] {
    CMD_AT        = 3'd0,
    CMD_RESET     = 3'd1,
    CMD_MODE      = 3'd2,
    CMD_JOIN      = 3'd3,
    CMD_TCP_OPEN  = 3'd4,
    CMD_LEAVE     = 3'd5,
    CMD_TCP_CLOSE = 3'd6,
    CMD_RESTORE   = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    DEV_LIGHT   = 2'd0,
    DEV_BUZZER  = 2'd1,
    DEV_FAN     = 2'd2,
    DEV_UNKNOWN = 2'd3
  } dev_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] timeout_short;
    logic [LIMIT_W-1:0] timeout_mode;
    logic [LIMIT_W-1:0] timeout_join;
    logic [LIMIT_W-1:0] timeout_tcp;
    logic [LIMIT_W-1:0] timeout_leave;
    logic [RETRY_W-1:0] retry_limit;
    logic [HOLD_W-1:0]  error_hold;
  } cfg_t;

  typedef struct packed {
    logic [7:0] ticks;
    logic       mode_req_valid;
    logic [1:0] mode_req;
    logic       line_ready;
    logic       line_has_ok;
    logic       line_has_ready;
    logic       ctrl_present;
    logic [1:0] ctrl_device;
    logic       ctrl_open;
  } item_t;

  typedef struct packed {
    logic              command_valid;
    cmd_t              command_code;
    logic              clear_buffer;
    mode_t             mode_now;
    conn_phase_t       connect_phase;
    disc_phase_t       disconnect_phase;
    logic              connected;
    logic              light_on;
    logic              buzzer_on;
    logic              fan_on;
    logic              unknown_device;
    logic [LAMP_W-1:0] error_lights;
  } res_t;

endpackage

// ===== hdl/mls_ifs.sv =====
// mls_ifs: valid/ready channel interfaces for poll words and result words
// no dependencies

interface mls_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ticks;
  logic       mode_req_valid;
  logic [1:0] mode_req;
  logic       line_ready;
  logic       line_has_ok;
  logic       line_has_ready;
  logic       ctrl_present;
  logic [1:0] ctrl_device;
  logic       ctrl_open;

  modport source (
    output valid, ticks, mode_req_valid, mode_req, line_ready, line_has_ok,
           line_has_ready, ctrl_present, ctrl_device, ctrl_open,
    input  ready
  );
  modport sink (
    input  valid, ticks, mode_req_valid, mode_req, line_ready, line_has_ok,
           line_has_ready, ctrl_present, ctrl_device, ctrl_open,
    output ready
  );
endinterface

interface mls_out_if;
  logic       valid;
  logic       ready;
  logic       command_valid;
  logic [2:0] command_code;
  logic       clear_buffer;
  logic [1:0] mode_now;
  logic [2:0] connect_phase;
  logic [1:0] disconnect_phase;
  logic       connected;
  logic       light_on;
  logic       buzzer_on;
  logic       fan_on;
  logic       unknown_device;
  logic [1:0] error_lights;

  modport source (
    output valid, command_valid, command_code, clear_buffer, mode_now,
           connect_phase, disconnect_phase, connected, light_on, buzzer_on,
           fan_on, unknown_device, error_lights,
    input  ready
  );
  modport sink (
    input  valid, command_valid, command_code, clear_buffer, mode_now,
           connect_phase, disconnect_phase, connected, light_on, buzzer_on,
           fan_on, unknown_device, error_lights,
    output ready
  );
endinterface

// ===== hdl/mls_cfg.sv =====
// mls_cfg: configuration register file (timeouts, retry limit, error hold)
// depends on mls_pkg

module mls_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [mls_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mls_pkg::CFG_DATA_W-1:0]    cfg_data,
  output mls_pkg::cfg_t                     cfg
);

  mls_pkg::cfg_t cfg_r;
  mls_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        mls_pkg::CFG_TIMEOUT_SHORT: cfg_nxt.timeout_short = cfg_data;
        mls_pkg::CFG_TIMEOUT_MODE:  cfg_nxt.timeout_mode  = cfg_data;
        mls_pkg::CFG_TIMEOUT_JOIN:  cfg_nxt.timeout_join  = cfg_data;
        mls_pkg::CFG_TIMEOUT_TCP:   cfg_nxt.timeout_tcp   = cfg_data;
        mls_pkg::CFG_TIMEOUT_LEAVE: cfg_nxt.timeout_leave = cfg_data;
        mls_pkg::CFG_RETRY_LIMIT:
          cfg_nxt.retry_limit = cfg_data[mls_pkg::RETRY_W-1:0];
        mls_pkg::CFG_ERROR_HOLD:
          cfg_nxt.error_hold = cfg_data[mls_pkg::HOLD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.timeout_short <= mls_pkg::RST_TIMEOUT_SHORT;
      cfg_r.timeout_mode  <= mls_pkg::RST_TIMEOUT_MODE;
      cfg_r.timeout_join  <= mls_pkg::RST_TIMEOUT_JOIN;
      cfg_r.timeout_tcp   <= mls_pkg::RST_TIMEOUT_TCP;
      cfg_r.timeout_leave <= mls_pkg::RST_TIMEOUT_LEAVE;
      cfg_r.retry_limit   <= mls_pkg::RST_RETRY_LIMIT;
      cfg_r.error_hold    <= mls_pkg::RST_ERROR_HOLD;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== hdl/mls_seq.sv =====
// mls_seq: link sequencer state and the per-poll next-state logic
// depends on mls_pkg; fed one registered poll word per step

module mls_seq #(
  parameter int TIMEOUT_WIDTH = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           step,
  input  mls_pkg::item_t item,
  input  mls_pkg::cfg_t  cfg,
  output mls_pkg::res_t  res
);

  localparam int TW = TIMEOUT_WIDTH;
  localparam int CW = (TIMEOUT_WIDTH > mls_pkg::LIMIT_W) ? TIMEOUT_WIDTH : mls_pkg::LIMIT_W;

  // state
  mls_pkg::mode_t                 mode_r, mode_nxt;
  mls_pkg::mode_t                 last_r;
  mls_pkg::conn_phase_t           conn_r, conn_nxt;
  mls_pkg::disc_phase_t           disc_r, disc_nxt;
  logic [TW-1:0]                  tc_r, tc_nxt;
  logic [mls_pkg::RETRY_W-1:0]    rc_r, rc_nxt;
  logic                           connected_r, connected_nxt;
  logic [mls_pkg::DEV_W-1:0]      dev_r, dev_nxt;
  logic [mls_pkg::HOLD_W-1:0]     conn_err_r, conn_err_nxt;
  logic [mls_pkg::HOLD_W-1:0]     disc_err_r, disc_err_nxt;
  logic [mls_pkg::LAMP_W-1:0]     lamps_r, lamps_nxt;

  // front of the poll: ticks, request, mode change
  logic [TW:0]                    tc_sum;
  logic [TW-1:0]                  tc_sat;
  logic                           req_ok;
  mls_pkg::mode_t                 mode_sel;
  logic                           chg;
  mls_pkg::conn_phase_t           conn_cur;
  mls_pkg::disc_phase_t           disc_cur;
  logic [TW-1:0]                  tc_cur;
  logic [mls_pkg::RETRY_W-1:0]    rc_cur;

  // phase decode
  logic                           waiting;
  logic                           want_ready;
  logic                           look_only;
  logic [mls_pkg::LIMIT_W-1:0]    limit;
  mls_pkg::cmd_t                  resend;
  mls_pkg::cmd_t                  fwd;
  logic                           fwd_ok;
  logic                           err_conn;
  logic                           err_disc;

  logic                           examine;
  logic                           hit;
  logic                           succeed;
  logic                           expired;
  logic                           again;
  logic                           ctrl_act;
  logic [mls_pkg::HOLD_W-1:0]     err_cnt;
  logic                           err_done;

  logic                           cmd_valid;
  mls_pkg::cmd_t                  cmd_code;
  logic                           clear;
  logic                           unknown;

  assign tc_sum = {1'b0, tc_r} + (TW + 1)'(item.ticks);
  assign tc_sat = tc_sum[TW] ? {TW{1'b1}} : tc_sum[TW-1:0];

  assign req_ok = item.mode_req_valid &&
                  (item.mode_req == mls_pkg::MODE_IDLE ||
                   item.mode_req == mls_pkg::MODE_CONNECT ||
                   item.mode_req == mls_pkg::MODE_DISCONNECT);
  assign mode_sel = req_ok ? mls_pkg::mode_t'(item.mode_req) : mode_r;
  assign chg      = (mode_sel != last_r);

  // a mode change restarts the sequence before the phase runs
  assign conn_cur = chg ? mls_pkg::CONN_WAIT_RESET : conn_r;
  assign disc_cur = chg ? mls_pkg::DISC_CLOSE : disc_r;
  assign tc_cur   = chg ? '0 : tc_sat;
  assign rc_cur   = chg ? '0 : rc_r;

  always_comb begin
    waiting    = 1'b0;
    want_ready = 1'b0;
    look_only  = 1'b0;
    limit      = '0;
    resend     = mls_pkg::CMD_AT;
    fwd        = mls_pkg::CMD_AT;
    fwd_ok     = 1'b0;
    err_conn   = 1'b0;
    err_disc   = 1'b0;
    case (mode_sel)
      mls_pkg::MODE_CONNECT: begin
        case (conn_cur)
          mls_pkg::CONN_WAIT_RESET: begin
            waiting    = 1'b1;
            want_ready = 1'b1;
            limit      = cfg.timeout_short;
            resend     = mls_pkg::CMD_RESET;
            fwd        = mls_pkg::CMD_AT;
            fwd_ok     = 1'b1;
          end
          mls_pkg::CONN_AT: begin
            waiting = 1'b1;
            limit   = cfg.timeout_short;
            resend  = mls_pkg::CMD_AT;
            fwd     = mls_pkg::CMD_MODE;
            fwd_ok  = 1'b1;
          end
          mls_pkg::CONN_MODE: begin
            waiting = 1'b1;
            limit   = cfg.timeout_mode;
            resend  = mls_pkg::CMD_MODE;
            fwd     = mls_pkg::CMD_JOIN;
            fwd_ok  = 1'b1;
          end
          mls_pkg::CONN_JOIN: begin
            waiting = 1'b1;
            limit   = cfg.timeout_join;
            resend  = mls_pkg::CMD_JOIN;
            fwd     = mls_pkg::CMD_TCP_OPEN;
            fwd_ok  = 1'b1;
          end
          mls_pkg::CONN_TCP: begin
            waiting = 1'b1;
            limit   = cfg.timeout_tcp;
            resend  = mls_pkg::CMD_TCP_OPEN;
          end
          mls_pkg::CONN_DONE: look_only = 1'b1;
          default: err_conn = 1'b1;
        endcase
      end
      mls_pkg::MODE_DISCONNECT: begin
        case (disc_cur)
          mls_pkg::DISC_CLOSE: begin
            waiting = 1'b1;
            limit   = cfg.timeout_short;
            resend  = mls_pkg::CMD_TCP_CLOSE;
            fwd     = mls_pkg::CMD_LEAVE;
            fwd_ok  = 1'b1;
          end
          mls_pkg::DISC_LEAVE: begin
            waiting = 1'b1;
            limit   = cfg.timeout_leave;
            resend  = mls_pkg::CMD_LEAVE;
            fwd     = mls_pkg::CMD_RESTORE;
            fwd_ok  = 1'b1;
          end
          mls_pkg::DISC_RESTORE: begin
            waiting    = 1'b1;
            want_ready = 1'b1;
            limit      = cfg.timeout_leave;
            resend     = mls_pkg::CMD_RESTORE;
          end
          default: err_disc = 1'b1;
        endcase
      end
      default: begin
      end
    endcase
  end

  // the line is not looked at in the poll that changes mode
  assign examine  = item.line_ready && !chg && (waiting || look_only);
  assign hit      = examine && (want_ready ? item.line_has_ready : item.line_has_ok);
  assign succeed  = waiting && hit;
  assign expired  = waiting && !hit && (CW'(tc_cur) > CW'(limit));
  assign again    = (rc_cur < cfg.retry_limit);
  assign ctrl_act = examine && item.ctrl_present;
  assign err_cnt  = err_conn ? conn_err_r : disc_err_r;
  assign err_done = (err_conn || err_disc) && (err_cnt > cfg.error_hold);

  // next state
  always_comb begin
    mode_nxt      = mode_sel;
    conn_nxt      = conn_cur;
    disc_nxt      = disc_cur;
    tc_nxt        = tc_cur;
    rc_nxt        = rc_cur;
    connected_nxt = connected_r;
    dev_nxt       = chg ? {dev_r[2:1], 1'b0} : dev_r;
    lamps_nxt     = chg ? '0 : lamps_r;
    conn_err_nxt  = conn_err_r;
    disc_err_nxt  = disc_err_r;

    if (ctrl_act) begin
      case (mls_pkg::dev_t'(item.ctrl_device))
        mls_pkg::DEV_LIGHT:  dev_nxt[0] = item.ctrl_open;
        mls_pkg::DEV_BUZZER: dev_nxt[1] = item.ctrl_open;
        mls_pkg::DEV_FAN:    dev_nxt[2] = item.ctrl_open;
        default: begin
        end
      endcase
    end

    if (expired) begin
      rc_nxt = (&rc_cur) ? rc_cur : rc_cur + 3'd1;
      if (again) begin
        tc_nxt = '0;
      end else if (mode_sel == mls_pkg::MODE_CONNECT) begin
        conn_nxt = mls_pkg::CONN_ERROR;
      end else begin
        disc_nxt = mls_pkg::DISC_ERROR;
      end
    end

    if (succeed) begin
      tc_nxt = '0;
      rc_nxt = '0;
      if (mode_sel == mls_pkg::MODE_CONNECT) begin
        conn_nxt = mls_pkg::conn_phase_t'(conn_cur + 3'd1);
        if (conn_cur == mls_pkg::CONN_TCP) begin
          connected_nxt = 1'b1;
        end
      end else if (disc_cur == mls_pkg::DISC_RESTORE) begin
        conn_nxt = mls_pkg::CONN_WAIT_RESET;
        disc_nxt = mls_pkg::DISC_CLOSE;
        mode_nxt = mls_pkg::MODE_IDLE;
      end else begin
        disc_nxt = mls_pkg::disc_phase_t'(disc_cur + 2'd1);
      end
    end

    if (err_conn) begin
      conn_nxt     = mls_pkg::CONN_ERROR;
      lamps_nxt[0] = 1'b1;
      if (!err_done && !(&conn_err_r)) begin
        conn_err_nxt = conn_err_r + 13'd1;
      end
    end
    if (err_disc) begin
      lamps_nxt[1] = 1'b1;
      if (!err_done && !(&disc_err_r)) begin
        disc_err_nxt = disc_err_r + 13'd1;
      end
    end

    // hold time used up: back to idle with a fresh sequence
    if (err_done) begin
      if (err_conn) begin
        conn_err_nxt = '0;
      end else begin
        disc_err_nxt = '0;
      end
      mode_nxt   = mls_pkg::MODE_IDLE;
      conn_nxt   = mls_pkg::CONN_WAIT_RESET;
      disc_nxt   = mls_pkg::DISC_CLOSE;
      tc_nxt     = '0;
      rc_nxt     = '0;
      dev_nxt[0] = 1'b0;
      lamps_nxt  = '0;
    end
  end

  // per-poll outputs
  always_comb begin
    cmd_valid = 1'b0;
    cmd_code  = mls_pkg::CMD_AT;
    if (expired && again) begin
      cmd_valid = 1'b1;
      cmd_code  = resend;
    end else if (succeed && fwd_ok) begin
      cmd_valid = 1'b1;
      cmd_code  = fwd;
    end
    clear   = chg || hit || err_done;
    unknown = ctrl_act && (item.ctrl_device == mls_pkg::DEV_UNKNOWN);
  end

  always_comb begin
    res.command_valid    = cmd_valid;
    res.command_code     = cmd_code;
    res.clear_buffer     = clear;
    res.mode_now         = mode_nxt;
    res.connect_phase    = conn_nxt;
    res.disconnect_phase = disc_nxt;
    res.connected        = connected_nxt;
    res.light_on         = dev_nxt[0];
    res.buzzer_on        = dev_nxt[1];
    res.fan_on           = dev_nxt[2];
    res.unknown_device   = unknown;
    res.error_lights     = lamps_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= mls_pkg::MODE_IDLE;
      last_r      <= mls_pkg::MODE_IDLE;
      conn_r      <= mls_pkg::CONN_WAIT_RESET;
      disc_r      <= mls_pkg::DISC_CLOSE;
      tc_r        <= '0;
      rc_r        <= '0;
      connected_r <= 1'b0;
      dev_r       <= '0;
      conn_err_r  <= '0;
      disc_err_r  <= '0;
      lamps_r     <= '0;
    end else if (step) begin
      mode_r      <= mode_nxt;
      last_r      <= mode_sel;
      conn_r      <= conn_nxt;
      disc_r      <= disc_nxt;
      tc_r        <= tc_nxt;
      rc_r        <= rc_nxt;
      connected_r <= connected_nxt;
      dev_r       <= dev_nxt;
      conn_err_r  <= conn_err_nxt;
      disc_err_r  <= disc_err_nxt;
      lamps_r     <= lamps_nxt;
    end
  end

endmodule

// ===== hdl/modem_link_sequencer.sv =====
// modem_link_sequencer: top level with input word register and result register
// depends on mls_pkg, mls_ifs, mls_cfg and mls_seq
//
// Usage: each poll word on in_ch carries elapsed ticks, an optional mode
// request and the flags of the pending modem reply line. For every poll word
// exactly one result word leaves on out_ch: the command to send (if any),
// whether to drop the reply line, the mode and phases after the poll, the
// sticky connected flag, the three device levels and the error lamps.
// A word is taken on a rising edge with valid and ready both high.
// Path: a poll word taken on in_ch waits in the input register; the
// sequencer logic loads its result into the result register, which drives
// out_ch, once that register is empty or out_ch.ready is high.
// Throughput: one poll word per cycle while out_ch.ready stays high; the
// sequencer logic is single-pass.
// Stall: while out_ch.ready is low the result register holds its word; the
// input register still takes one more poll word, then in_ch.ready drops.
// Reset (rst_n low, synchronous) empties both registers, puts the mode to
// idle with all phases, counters, devices and lamps cleared, and loads the
// default timeouts, retry limit and error hold.
// Configuration: cfg_we writes register cfg_index with cfg_data; write only
// while no poll word is in flight.

module modem_link_sequencer #(
  parameter int TIMEOUT_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  mls_in_if.sink                         in_ch,
  mls_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [mls_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mls_pkg::CFG_DATA_W-1:0] cfg_data
);

  mls_pkg::cfg_t  cfg;
  mls_pkg::item_t item_r;
  logic           in_valid_r;
  mls_pkg::res_t  res;
  mls_pkg::res_t  res_r;
  logic           out_valid_r;
  logic           step;

  assign step        = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      item_r.ticks          <= in_ch.ticks;
      item_r.mode_req_valid <= in_ch.mode_req_valid;
      item_r.mode_req       <= in_ch.mode_req;
      item_r.line_ready     <= in_ch.line_ready;
      item_r.line_has_ok    <= in_ch.line_has_ok;
      item_r.line_has_ready <= in_ch.line_has_ready;
      item_r.ctrl_present   <= in_ch.ctrl_present;
      item_r.ctrl_device    <= in_ch.ctrl_device;
      item_r.ctrl_open      <= in_ch.ctrl_open;
    end
  end

  mls_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mls_seq #(
    .TIMEOUT_WIDTH (TIMEOUT_WIDTH)
  ) u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (step),
    .item  (item_r),
    .cfg   (cfg),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_r <= res;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.command_valid    = res_r.command_valid;
  assign out_ch.command_code     = res_r.command_code;
  assign out_ch.clear_buffer     = res_r.clear_buffer;
  assign out_ch.mode_now         = res_r.mode_now;
  assign out_ch.connect_phase    = res_r.connect_phase;
  assign out_ch.disconnect_phase = res_r.disconnect_phase;
  assign out_ch.connected        = res_r.connected;
  assign out_ch.light_on         = res_r.light_on;
  assign out_ch.buzzer_on        = res_r.buzzer_on;
  assign out_ch.fan_on           = res_r.fan_on;
  assign out_ch.unknown_device   = res_r.unknown_device;
  assign out_ch.error_lights     = res_r.error_lights;

endmodule

// ===== hdl/mls_checker.sv =====
// mls_checker: port-level assertions on the modem link sequencer results
// depends on mls_pkg; bound to modem_link_sequencer at the end of this file

module mls_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic       command_valid,
  input logic [2:0] command_code,
  input logic [1:0] mode_now,
  input logic [2:0] connect_phase,
  input logic [1:0] disconnect_phase,
  input logic       connected,
  input logic [1:0] error_lights
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(command_code) &&
    $stable(connect_phase) && $stable(disconnect_phase) && $stable(error_lights))
    else $error("result word changed while stalled");

  a_code_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !command_valid |-> command_code == mls_pkg::CMD_AT)
    else $error("command code set without a command");

  // a lit lamp means the matching sequence sits in its error phase
  a_conn_lamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && error_lights[0] |->
      mode_now == mls_pkg::MODE_CONNECT && connect_phase == mls_pkg::CONN_ERROR)
    else $error("connect lamp lit outside the connect error phase");

  a_disc_lamp: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && error_lights[1] |->
      mode_now == mls_pkg::MODE_DISCONNECT && disconnect_phase == mls_pkg::DISC_ERROR)
    else $error("disconnect lamp lit outside the disconnect error phase");

  a_connected_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && connected |=> !out_valid || connected)
    else $error("connected flag dropped");

endmodule

bind modem_link_sequencer mls_checker u_mls_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .command_valid    (out_ch.command_valid),
  .command_code     (out_ch.command_code),
  .mode_now         (out_ch.mode_now),
  .connect_phase    (out_ch.connect_phase),
  .disconnect_phase (out_ch.disconnect_phase),
  .connected        (out_ch.connected),
  .error_lights     (out_ch.error_lights)
);
